@@ rtl/tsb_pkg.sv @@
// Shared types and constants for the trace stream buffer.
// Used by tsb_front, tsb_back and trace_stream_buffer_unit; no dependencies.
package tsb_pkg;

   localparam int BYTE_W      = 8;
   localparam int CMD_W       = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int KIND_W      = 3;
   localparam int RING_DEPTH_DEF = 1024;

   // Input commands
   localparam logic [CMD_W-1:0] CMD_PUT_RAW  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_DATA = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLR_SUM  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FLAG   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK   = 2'd2;

   // Register reset values
   localparam logic [BYTE_W-1:0] FLAG_RST   = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
   localparam logic [BYTE_W-1:0] MASK_RST   = 8'd32;

   // Operation kinds passed from front to back
   localparam logic [KIND_W-1:0] OP_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] OP_PUT     = 3'd1;
   localparam logic [KIND_W-1:0] OP_PUT_ESC = 3'd2;
   localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd3;
   localparam logic [KIND_W-1:0] OP_READ    = 3'd4;
   localparam logic [KIND_W-1:0] OP_RESTART = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              add_sum;
      logic [BYTE_W-1:0] sum_byte;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
   } op_type;

endpackage

@@ rtl/tsb_front.sv @@
// Front end: configuration registers, command classification and escaping,
// and a two-entry operation queue toward the back end. Depends on tsb_pkg.
module tsb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tsb_pkg::CMD_W-1:0]      req_command,
   input  logic [tsb_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsb_pkg::BYTE_W-1:0]     csr_wdata,
   output logic                           op_valid,
   output tsb_pkg::op_type                op,
   input  logic                           op_pop
);

   logic [tsb_pkg::BYTE_W-1:0] flag_ff, escape_ff, mask_ff;
   tsb_pkg::op_type            op_new;
   tsb_pkg::op_type            queue_ff [2];
   logic                       head_ff, head_in;
   logic [1:0]                 count_ff, count_in;
   logic                       push;
   logic                       tail;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= tsb_pkg::FLAG_RST;
         escape_ff <= tsb_pkg::ESCAPE_RST;
         mask_ff   <= tsb_pkg::MASK_RST;
      end else if (csr_valid) begin
         case (csr_index)
            tsb_pkg::REG_FLAG:   flag_ff   <= csr_wdata;
            tsb_pkg::REG_ESCAPE: escape_ff <= csr_wdata;
            tsb_pkg::REG_MASK:   mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify the command into one back-end operation
   always_comb begin
      op_new          = '0;
      op_new.kind     = tsb_pkg::OP_NONE;
      op_new.sum_byte = req_data_byte;
      op_new.b0       = req_data_byte;
      op_new.b1       = req_data_byte ^ mask_ff;
      case (req_command)
         tsb_pkg::CMD_PUT_RAW: begin
            op_new.kind = tsb_pkg::OP_PUT;
         end
         tsb_pkg::CMD_PUT_DATA: begin
            op_new.add_sum = 1'b1;
            if (req_data_byte == flag_ff || req_data_byte == escape_ff) begin
               op_new.kind = tsb_pkg::OP_PUT_ESC;
               op_new.b0   = escape_ff;
            end else begin
               op_new.kind = tsb_pkg::OP_PUT;
            end
         end
         tsb_pkg::CMD_CLR_SUM: op_new.kind = tsb_pkg::OP_CLEAR;
         tsb_pkg::CMD_READ:    op_new.kind = tsb_pkg::OP_READ;
         tsb_pkg::CMD_RESTART: begin
            op_new.kind = tsb_pkg::OP_RESTART;
            op_new.b0   = flag_ff;
         end
         default: op_new.kind = tsb_pkg::OP_NONE;
      endcase
   end

   // Two-entry queue
   assign busy     = (count_ff == 2'd2);
   assign push     = start && !busy;
   assign tail     = head_ff ^ count_ff[0];
   assign op_valid = (count_ff != 2'd0);
   assign op       = queue_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (op_pop && op_valid) begin
         head_in  = ~head_ff;
         count_in = count_in - 2'd1;
      end
      if (push) begin
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail] <= op_new;
      end
   end

endmodule

@@ rtl/tsb_back.sv @@
// Back end: ring memory, ring pointers, running sum and result register.
// Executes operations from tsb_front. Depends on tsb_pkg.
module tsb_back #(
   parameter int RING_DEPTH = tsb_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_valid,
   input  tsb_pkg::op_type                   op,
   output logic                              op_pop,
   output logic                              rsp_strobe,
   output logic [tsb_pkg::BYTE_W-1:0]        rsp_read_byte,
   output logic                              rsp_read_valid,
   output logic [tsb_pkg::BYTE_W-1:0]        rsp_running_sum,
   output logic [$clog2(RING_DEPTH+1)-1:0]   rsp_fill_count
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH+1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SECOND = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [IDX_W-1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]           held_ff, held_in;
   logic [tsb_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [tsb_pkg::BYTE_W-1:0] second_ff, second_in;

   logic [tsb_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [tsb_pkg::BYTE_W-1:0] mem_rd_ff;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_addr;
   logic [tsb_pkg::BYTE_W-1:0] mem_wdata;

   logic                       do_push;
   logic [tsb_pkg::BYTE_W-1:0] push_byte;
   logic [IDX_W-1:0]           base_wr, base_rd, wr_inc;
   logic [CNT_W-1:0]           base_held;
   logic [CNT_W:0]             held_inc;

   logic                       emit, emit_rv;
   logic [tsb_pkg::BYTE_W-1:0] emit_rb;

   logic                       strobe_ff, rv_ff;
   logic [tsb_pkg::BYTE_W-1:0] rb_ff, out_sum_ff;
   logic [CNT_W-1:0]           out_fill_ff;

   logic [CNT_W-1:0]           ptr_dist;

   // Operation sequencer and ring update
   always_comb begin
      state_in  = state_ff;
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      held_in   = held_ff;
      sum_in    = sum_ff;
      second_in = second_ff;
      op_pop    = 1'b0;
      do_push   = 1'b0;
      push_byte = op.b0;
      base_wr   = wr_ff;
      base_rd   = rd_ff;
      base_held = held_ff;
      mem_we    = 1'b0;
      mem_addr  = wr_ff;
      mem_wdata = op.b0;
      emit      = 1'b0;
      emit_rv   = 1'b0;
      emit_rb   = '0;
      wr_inc    = '0;
      held_inc  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_pop = 1'b1;
               case (op.kind)
                  tsb_pkg::OP_PUT: begin
                     do_push = 1'b1;
                     if (op.add_sum) sum_in = sum_ff + op.sum_byte;
                     emit = 1'b1;
                  end
                  tsb_pkg::OP_PUT_ESC: begin
                     do_push   = 1'b1;
                     sum_in    = sum_ff + op.sum_byte;
                     second_in = op.b1;
                     state_in  = ST_SECOND;
                  end
                  tsb_pkg::OP_CLEAR: begin
                     sum_in = '0;
                     emit   = 1'b1;
                  end
                  tsb_pkg::OP_READ: begin
                     if (held_ff != '0) begin
                        mem_addr = rd_ff;
                        rd_in    = (rd_ff == IDX_W'(RING_DEPTH-1)) ? '0
                                                                  : rd_ff + IDX_W'(1);
                        held_in  = held_ff - CNT_W'(1);
                        state_in = ST_READ;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  tsb_pkg::OP_RESTART: begin
                     base_wr   = '0;
                     base_rd   = '0;
                     base_held = '0;
                     do_push   = 1'b1;
                     emit      = 1'b1;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_SECOND: begin
            do_push   = 1'b1;
            push_byte = second_ff;
            emit      = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            emit     = 1'b1;
            emit_rv  = 1'b1;
            emit_rb  = mem_rd_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // One byte into the ring; a full ring drops its oldest byte
      if (do_push) begin
         mem_we    = 1'b1;
         mem_addr  = base_wr;
         mem_wdata = push_byte;
         wr_inc    = (base_wr == IDX_W'(RING_DEPTH-1)) ? '0 : base_wr + IDX_W'(1);
         held_inc  = {1'b0, base_held} + (CNT_W+1)'(1);
         wr_in     = wr_inc;
         if (held_inc >= (CNT_W+1)'(RING_DEPTH)) begin
            held_in = CNT_W'(RING_DEPTH);
            rd_in   = wr_inc;
         end else begin
            held_in = held_inc[CNT_W-1:0];
            rd_in   = base_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wr_ff    <= '0;
         rd_ff    <= '0;
         held_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         held_ff  <= held_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      second_ff <= second_in;
   end

   // Single-port ring memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= ring_mem[mem_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         strobe_ff <= emit;
         rv_ff     <= emit_rv;
      end
   end

   always_ff @(posedge clock) begin
      rb_ff       <= emit_rb;
      out_sum_ff  <= sum_in;
      out_fill_ff <= held_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_read_valid  = rv_ff;
   assign rsp_read_byte   = rb_ff;
   assign rsp_running_sum = out_sum_ff;
   assign rsp_fill_count  = out_fill_ff;

   // Distance from read to write pointer, for the pointer check
   assign ptr_dist = (wr_ff >= rd_ff) ? CNT_W'(wr_ff - rd_ff)
                                      : CNT_W'(RING_DEPTH) - CNT_W'(rd_ff) + CNT_W'(wr_ff);

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(RING_DEPTH))
      else $error("ring fill count above depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0 || held_ff == CNT_W'(RING_DEPTH)) ? (wr_ff == rd_ff)
                                                      : (ptr_dist == held_ff))
      else $error("ring pointers disagree with fill count");

   a_second_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SECOND |=> state_ff == ST_IDLE && rsp_strobe)
      else $error("escape second write did not finish the item");

   a_read_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_read_valid |-> rsp_strobe && $past(state_ff) == ST_READ)
      else $error("read data presented outside a read transaction");

   a_empty_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_read_valid |-> rsp_read_byte == '0)
      else $error("nonzero read byte without a popped byte");
`endif

endmodule

@@ rtl/trace_stream_buffer_unit.sv @@
// Top level of the trace stream buffer: front end, back end and result ports.
// Depends on tsb_pkg, tsb_front and tsb_back.
//
// Commands enter on start while busy is low and land in a two-entry queue;
// the back end executes them one at a time against a single-port ring memory.
// Put raw, unescaped put data, clear sum, restart and unused commands take one
// back-end cycle; an escaped data byte takes two (two writes on the one memory
// port); a read of a non-empty ring takes two (address, then registered data).
// Each command gives exactly one result, one cycle after its last back-end
// cycle, on rsp_strobe for a single cycle: the receiver must take it then.
// The ring needs no clearing after reset; only written entries are ever read.
// Configuration writes are always accepted and should be made while idle.
module trace_stream_buffer_unit #(
   parameter int RING_DEPTH = tsb_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tsb_pkg::CMD_W-1:0]         req_command,
   input  logic [tsb_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                              rsp_strobe,
   output logic [tsb_pkg::BYTE_W-1:0]        rsp_read_byte,
   output logic                              rsp_read_valid,
   output logic [tsb_pkg::BYTE_W-1:0]        rsp_running_sum,
   output logic [$clog2(RING_DEPTH+1)-1:0]   rsp_fill_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tsb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsb_pkg::BYTE_W-1:0]        csr_wdata
);

   logic            op_valid;
   logic            op_pop;
   tsb_pkg::op_type op;

   // Accept, classify and queue
   tsb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .op_valid      (op_valid),
      .op            (op),
      .op_pop        (op_pop)
   );

   // Execute against the ring
   tsb_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_running_sum (rsp_running_sum),
      .rsp_fill_count  (rsp_fill_count)
   );

endmodule
